[hw/rtl/asymmetric_curved_glide_assert.svh]
// assertion macros for the glide block
// expects aclk and aresetn in the including scope
`ifndef ASYMMETRIC_CURVED_GLIDE_ASSERT_SVH
`define ASYMMETRIC_CURVED_GLIDE_ASSERT_SVH

// condition holds in the same cycle
`define ACG_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("glide check failed");

// condition holds in the next cycle
`define ACG_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("glide check failed");

`endif

[hw/rtl/acg_pkg.sv]
// shared types, constants and exp2 factor table for the glide block
// no dependencies
package acg_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int SAMPLE_BITS  = 24;
    localparam int LENGTH_BITS  = 16;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam logic [16:0] Q_ONE = 17'h10000;
    localparam logic [15:0] EXP_LINEAR = 16'd256;
    localparam logic [15:0] EXP_RESET  = 16'sd256;

    typedef struct packed {
        logic [3:0]                    channel;
        logic signed [SAMPLE_BITS-1:0] target;
        logic [LENGTH_BITS-1:0]        rise;
        logic [LENGTH_BITS-1:0]        fall;
        logic                          snap;
        logic                          in_range;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              pop;
    } front_st_t;

    typedef struct packed {
        logic busy;
        logic done;
    } back_st_t;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_FSEL, S_DIV, S_SHAPE, S_POW, S_MUL, S_SUM
    } back_state_t;

    typedef enum logic [2:0] {
        P_IDLE, P_LOG, P_MULP, P_EXP, P_SHIFT, P_DONE
    } pow_state_t;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        rem  = v;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > rem) bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // factor 2^(-2^-(idx+1)) in q0.30
    function automatic logic [29:0] fac_at(int idx);
        logic [63:0] f;
        f = isqrt64(64'd1 << 59);
        for (int j = 0; j < idx; j++) begin
            f = isqrt64(f << 30);
        end
        return f[29:0];
    endfunction

    localparam logic [29:0] FAC_TAB [16] = '{
        fac_at(0),  fac_at(1),  fac_at(2),  fac_at(3),
        fac_at(4),  fac_at(5),  fac_at(6),  fac_at(7),
        fac_at(8),  fac_at(9),  fac_at(10), fac_at(11),
        fac_at(12), fac_at(13), fac_at(14), fac_at(15)
    };

endpackage

[hw/rtl/acg_front.sv]
// front end: accepts input words, decodes fields, short queue to the back end
// depends on acg_pkg
module acg_front #(
    parameter int CHANNELS = acg_pkg::CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [63:0]        s_data,
    input  logic               s_user,
    output logic               q_valid,
    output acg_pkg::item_t     q_item,
    input  logic               q_pop,
    output acg_pkg::front_st_t st
);

    acg_pkg::item_t                  mem_reg [acg_pkg::QDEPTH];
    logic [acg_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [acg_pkg::QCNT_W-1:0]      count_reg;
    acg_pkg::item_t                  dec;
    logic                            push, pop;

    always_comb begin
        dec.channel  = s_data[3:0];
        dec.target   = s_data[27:4];
        dec.rise     = s_data[43:28];
        dec.fall     = s_data[59:44];
        dec.snap     = s_user;
        dec.in_range = (32'(s_data[3:0]) < CHANNELS);
    end

    assign s_ready = (32'(count_reg) < acg_pkg::QDEPTH);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];
    assign st.count = count_reg;
    assign st.pop   = pop;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (32'(wr_ptr_reg) == acg_pkg::QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (32'(rd_ptr_reg) == acg_pkg::QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + QCNT_ONE(push) - QCNT_ONE(pop);
        end
    end

    function automatic logic [acg_pkg::QCNT_W-1:0] QCNT_ONE(logic b);
        return {{(acg_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

endmodule

[hw/rtl/acg_pow.sv]
// power unit: x^p with x and y in q1.16 and p in q8.8 via bit-serial log2 and a product of exp2 factors
// depends on acg_pkg (state type, factor table)
module acg_pow (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] x,
    input  logic [15:0] p,
    output logic        done,
    output logic [16:0] y
);

    acg_pkg::pow_state_t state_reg, state_next;
    logic [15:0] z_reg, z_next;
    logic [15:0] lf_reg, lf_next;
    logic [3:0]  e_reg, e_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] p_reg, p_next;
    logic [4:0]  ti_reg, ti_next;
    logic [15:0] tf_reg, tf_next;
    logic [30:0] r_reg, r_next;
    logic [16:0] y_reg, y_next;

    logic [3:0]  msb;
    logic [31:0] sq;
    logic [16:0] zs;
    logic [20:0] nl;
    logic [36:0] np;
    logic [60:0] rp;
    logic [30:0] rs;

    always_comb begin
        msb = '0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) msb = 4'(i);
        end
    end

    assign sq = z_reg * z_reg;
    assign zs = sq[31:15];
    assign nl = {5'(5'd16 - {1'b0, e_reg}), 16'b0} - {5'b0, lf_reg};
    assign np = nl * p_reg;
    assign rp = r_reg * {1'b0, acg_pkg::FAC_TAB[cnt_reg]};
    assign rs = r_reg >> (5'd14 + ti_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= acg_pkg::P_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        z_reg   <= z_next;
        lf_reg  <= lf_next;
        e_reg   <= e_next;
        cnt_reg <= cnt_next;
        p_reg   <= p_next;
        ti_reg  <= ti_next;
        tf_reg  <= tf_next;
        r_reg   <= r_next;
        y_reg   <= y_next;
    end

    always_comb begin
        state_next = state_reg;
        z_next = z_reg; lf_next = lf_reg; e_next = e_reg; cnt_next = cnt_reg;
        p_next = p_reg; ti_next = ti_reg; tf_next = tf_reg; r_next = r_reg;
        y_next = y_reg;
        done = 1'b0;
        case (state_reg)
            acg_pkg::P_IDLE: begin
                if (start) begin
                    p_next = p;
                    if (p == '0 || x >= acg_pkg::Q_ONE) begin
                        y_next = acg_pkg::Q_ONE;
                        state_next = acg_pkg::P_DONE;
                    end else if (x == '0) begin
                        y_next = '0;
                        state_next = acg_pkg::P_DONE;
                    end else begin
                        e_next   = msb;
                        z_next   = x[15:0] << (4'd15 - msb);
                        lf_next  = '0;
                        cnt_next = '0;
                        state_next = acg_pkg::P_LOG;
                    end
                end
            end
            acg_pkg::P_LOG: begin
                if (zs[16]) begin
                    lf_next = {lf_reg[14:0], 1'b1};
                    z_next  = zs[16:1];
                end else begin
                    lf_next = {lf_reg[14:0], 1'b0};
                    z_next  = zs[15:0];
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) state_next = acg_pkg::P_MULP;
            end
            acg_pkg::P_MULP: begin
                // t = nl * p / 256, integer part limits the exponent
                tf_next  = np[23:8];
                ti_next  = np[28:24];
                r_next   = 31'd1 << 30;
                cnt_next = '0;
                if (np[36:24] >= 13'd17) begin
                    y_next = '0;
                    state_next = acg_pkg::P_DONE;
                end else begin
                    state_next = acg_pkg::P_EXP;
                end
            end
            acg_pkg::P_EXP: begin
                if (tf_reg[4'd15 - cnt_reg]) r_next = rp[60:30];
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) state_next = acg_pkg::P_SHIFT;
            end
            acg_pkg::P_SHIFT: begin
                y_next = (rs > 31'(acg_pkg::Q_ONE)) ? acg_pkg::Q_ONE : rs[16:0];
                state_next = acg_pkg::P_DONE;
            end
            acg_pkg::P_DONE: begin
                done = 1'b1;
                state_next = acg_pkg::P_IDLE;
            end
            default: state_next = acg_pkg::P_IDLE;
        endcase
    end

    assign y = y_reg;

endmodule

[hw/rtl/acg_back.sv]
// back end: per-channel glide state, ramp fraction divider, shaping, output register
// depends on acg_pkg and acg_pow
module acg_back #(
    parameter int CHANNELS = acg_pkg::CHANNELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [15:0]            curve_exponent,
    input  logic                          q_valid,
    input  acg_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_channel,
    output logic [acg_pkg::SAMPLE_BITS-1:0] m_glided,
    output acg_pkg::back_st_t             st
);

    localparam int SB    = acg_pkg::SAMPLE_BITS;
    localparam int LB    = acg_pkg::LENGTH_BITS;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [SB-1:0] ptgt_reg  [CHANNELS];
    logic signed [SB-1:0] pout_reg  [CHANNELS];
    logic signed [SB-1:0] start_arr [CHANNELS];
    logic signed [SB:0]   delta_arr [CHANNELS];
    logic [LB-1:0]        left_arr  [CHANNELS];

    acg_pkg::back_state_t state_reg, state_next;
    acg_pkg::item_t       item_reg, item_next;
    logic [LB:0]          n_reg, n_next;
    logic [LB-1:0]        left_reg, left_next;
    logic signed [SB-1:0] start_reg, start_next;
    logic signed [SB:0]   delta_reg, delta_next;
    logic [16:0]          f_reg, f_next;
    logic [LB:0]          rem_reg, rem_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [16:0]          s_reg, s_next;
    logic                 direct_reg, direct_next;
    logic signed [SB+18:0] prod_reg, prod_next;
    logic                 out_valid_reg;
    logic [3:0]           out_ch_reg;
    logic signed [SB-1:0] out_y_reg;
    logic signed [SB-1:0] y_reg, y_next;
    logic                 emit_reg, emit_next;

    logic [IDX_W-1:0]     idx;
    logic signed [SB:0]   new_delta, cur_delta;
    logic [LB-1:0]        len;
    logic                 chg;
    logic [LB+1:0]        rem2;
    logic [15:0]          mag;
    logic                 rise;
    logic                 pow_start, pow_done;
    logic [16:0]          pow_x, pow_y;
    logic signed [SB+2:0] inc, sum;
    logic signed [SB-1:0] sat;
    logic                 wr_ramp, wr_pout, wr_ptgt, wr_left;
    logic                 out_load;

    assign idx       = IDX_W'(item_reg.channel);
    assign chg       = item_reg.target != ptgt_reg[idx];
    assign new_delta = (SB+1)'(item_reg.target) - (SB+1)'(pout_reg[idx]);
    assign cur_delta = chg ? new_delta : delta_arr[idx];
    assign len       = (cur_delta > 0) ? item_reg.rise : item_reg.fall;
    assign rem2      = {rem_reg, 1'b0};
    assign mag       = curve_exponent[15] ? 16'(-curve_exponent) : 16'(curve_exponent);
    assign rise      = delta_reg > 0;
    assign pow_x     = direct_next ? f_reg : acg_pkg::Q_ONE - f_reg;
    assign inc       = (SB+3)'((prod_reg + 32768) >>> 16);
    assign sum       = (SB+3)'(start_reg) + inc;
    assign sat       = (sum > $signed((SB+3)'({1'b0, {(SB-1){1'b1}}}))) ?
                       {1'b0, {(SB-1){1'b1}}} :
                       (sum < -$signed((SB+3)'({1'b1, {(SB-1){1'b0}}}))) ?
                       {1'b1, {(SB-1){1'b0}}} : sum[SB-1:0];
    assign out_load  = emit_reg && (!out_valid_reg || m_ready);

    acg_pow u_pow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pow_start),
        .x       (pow_x),
        .p       (mag),
        .done    (pow_done),
        .y       (pow_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= acg_pkg::S_IDLE;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                ptgt_reg[i]  <= '0;
                pout_reg[i]  <= '0;
                start_arr[i] <= '0;
                delta_arr[i] <= '0;
                left_arr[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
            if (out_load)               out_valid_reg <= 1'b1;
            else if (m_ready)           out_valid_reg <= 1'b0;
            if (wr_ptgt) ptgt_reg[idx] <= item_reg.target;
            if (wr_pout) pout_reg[idx] <= y_next;
            if (wr_left) left_arr[idx] <= left_next;
            if (wr_ramp) begin
                start_arr[idx] <= pout_reg[idx];
                delta_arr[idx] <= new_delta;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        n_reg      <= n_next;
        left_reg   <= left_next;
        start_reg  <= start_next;
        delta_reg  <= delta_next;
        f_reg      <= f_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        s_reg      <= s_next;
        direct_reg <= direct_next;
        prod_reg   <= prod_next;
        y_reg      <= y_next;
        if (out_load) begin
            out_ch_reg <= item_reg.channel;
            out_y_reg  <= y_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        item_next = item_reg; n_next = n_reg; left_next = left_reg;
        start_next = start_reg; delta_next = delta_reg; f_next = f_reg;
        rem_next = rem_reg; cnt_next = cnt_reg; s_next = s_reg;
        direct_next = direct_reg; prod_next = prod_reg; y_next = y_reg;
        emit_next = emit_reg && !out_load;
        q_pop = 1'b0; pow_start = 1'b0;
        wr_ramp = 1'b0; wr_pout = 1'b0; wr_ptgt = 1'b0; wr_left = 1'b0;
        case (state_reg)
            acg_pkg::S_IDLE: begin
                if (q_valid && !emit_reg) begin
                    q_pop = 1'b1;
                    item_next = q_item;
                    state_next = acg_pkg::S_LOAD;
                end
            end
            acg_pkg::S_LOAD: begin
                n_next = {1'b0, len} + 1'b1;
                if (!item_reg.in_range) begin
                    y_next = item_reg.target;
                    emit_next = 1'b1;
                    state_next = acg_pkg::S_IDLE;
                end else if (item_reg.snap) begin
                    y_next = item_reg.target;
                    left_next = '0;
                    wr_left = 1'b1; wr_pout = 1'b1; wr_ptgt = 1'b1;
                    emit_next = 1'b1;
                    state_next = acg_pkg::S_IDLE;
                end else if (chg) begin
                    wr_ramp = 1'b1; wr_ptgt = 1'b1; wr_left = 1'b1;
                    left_next  = len;
                    start_next = pout_reg[idx];
                    delta_next = new_delta;
                    state_next = acg_pkg::S_FSEL;
                end else if (left_arr[idx] != '0) begin
                    wr_left = 1'b1;
                    left_next  = left_arr[idx] - 1'b1;
                    start_next = start_arr[idx];
                    delta_next = delta_arr[idx];
                    state_next = acg_pkg::S_FSEL;
                end else begin
                    y_next = item_reg.target;
                    wr_pout = 1'b1;
                    emit_next = 1'b1;
                    state_next = acg_pkg::S_IDLE;
                end
            end
            acg_pkg::S_FSEL: begin
                cnt_next = '0;
                f_next   = '0;
                if ({1'b0, left_reg} >= n_reg) begin
                    f_next = '0;
                    state_next = acg_pkg::S_SHAPE;
                end else if (left_reg == '0) begin
                    f_next = acg_pkg::Q_ONE;
                    state_next = acg_pkg::S_SHAPE;
                end else begin
                    rem_next = n_reg - {1'b0, left_reg};
                    state_next = acg_pkg::S_DIV;
                end
            end
            acg_pkg::S_DIV: begin
                // restoring division, one quotient bit a cycle
                if (rem2 >= {1'b0, n_reg}) begin
                    rem_next = (LB+1)'(rem2 - {1'b0, n_reg});
                    f_next = {f_reg[15:0], 1'b1};
                end else begin
                    rem_next = rem2[LB:0];
                    f_next = {f_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) state_next = acg_pkg::S_SHAPE;
            end
            acg_pkg::S_SHAPE: begin
                direct_next = curve_exponent[15] ? !rise : rise;
                if (mag == acg_pkg::EXP_LINEAR) begin
                    s_next = f_reg;
                    state_next = acg_pkg::S_MUL;
                end else begin
                    pow_start = 1'b1;
                    state_next = acg_pkg::S_POW;
                end
            end
            acg_pkg::S_POW: begin
                if (pow_done) begin
                    s_next = direct_reg ? pow_y : acg_pkg::Q_ONE - pow_y;
                    state_next = acg_pkg::S_MUL;
                end
            end
            acg_pkg::S_MUL: begin
                prod_next = (SB+19)'($signed({1'b0, s_reg}) * delta_reg);
                state_next = acg_pkg::S_SUM;
            end
            acg_pkg::S_SUM: begin
                y_next = sat;
                wr_pout = 1'b1;
                emit_next = 1'b1;
                state_next = acg_pkg::S_IDLE;
            end
            default: state_next = acg_pkg::S_IDLE;
        endcase
    end

    assign m_valid   = out_valid_reg;
    assign m_channel = out_ch_reg;
    assign m_glided  = out_y_reg;
    assign st.busy   = (state_reg != acg_pkg::S_IDLE) || emit_reg;
    assign st.done   = out_load;

endmodule

[hw/rtl/asymmetric_curved_glide.sv]
// top level of the asymmetric curved glide: front queue, back end, exponent register
// depends on acg_pkg, acg_front, acg_back, acg_pow and the assertion header
//
// channel  dir  tdata / data bits                        tuser
// s_axis   in   channel[3:0] target[27:4] rise[43:28]    snap
//                fall[59:44]
// m_axis   out  out_channel[3:0] glided[27:4]            -
// cfg      in   curve_exponent[15:0] on cfg_we           -
//
// a ramping word may pass through the fraction divider, and when the curve is not
// linear also through the power unit (log2 squarings, then exp2 products)
// aresetn is synchronous; it clears all channel state and sets the exponent to 1.0
// two words queue at the input and one result waits in the output register
module asymmetric_curved_glide #(
    parameter int CHANNELS = acg_pkg::CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // channel, target, rise_samples, fall_samples
    input  logic        s_axis_tuser,   // snap
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_channel, glided
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    `include "asymmetric_curved_glide_assert.svh"

    logic signed [15:0]   curve_exponent_reg;
    logic                 q_valid, q_pop;
    acg_pkg::item_t       q_item;
    acg_pkg::front_st_t   front_st;
    acg_pkg::back_st_t    back_st;
    logic [3:0]           m_channel;
    logic [acg_pkg::SAMPLE_BITS-1:0] m_glided;

    always_ff @(posedge aclk) begin
        if (!aresetn)    curve_exponent_reg <= acg_pkg::EXP_RESET;
        else if (cfg_we) curve_exponent_reg <= cfg_wdata;
    end

    acg_front #(.CHANNELS(CHANNELS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .st      (front_st)
    );

    acg_back #(.CHANNELS(CHANNELS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .curve_exponent (curve_exponent_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_channel      (m_channel),
        .m_glided       (m_glided),
        .st             (back_st)
    );

    assign m_axis_tdata = {4'b0, m_glided, m_channel};

    `ACG_ASSERT_SAME(a_ready_full, !s_axis_tready, 32'(front_st.count) == acg_pkg::QDEPTH)
    `ACG_ASSERT_SAME(a_pop_idle, front_st.pop, !back_st.busy)
    `ACG_ASSERT_NEXT(a_done_valid, back_st.done, m_axis_tvalid)

endmodule
